FILE: sv/ffba_pkg.sv
// shared types and constants for the first-fit block allocator
`default_nettype none

package ffba_pkg;

    localparam int HEAP_BLOCKS_DEF = 1024;

    localparam int SIZE_W   = 11;
    localparam int INDEX_W  = 11;
    localparam int STATUS_W = 2;
    localparam int GRANT_W  = 10;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE   = 2'd0,
        ST_NO_FIT = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

endpackage

`default_nettype wire

FILE: sv/ffba_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/first_fit_block_allocator_unit.sv
// first-fit block allocator: free list sequencer over link and length rams
//
// Usage: raise start with i_func, i_size_blocks and i_block_index while busy
// is low; the request is taken at that clock edge. Exactly one result beat
// follows: o_done is high for one cycle with o_status and o_granted_block.
// The receiver cannot hold a result off; busy is low in the cycle that o_done
// is high, so a new request can be taken there.
//
// Sequence from the accepting edge to the o_done cycle:
//   zero-size allocate or out-of-range free: answered straight from idle
//   allocate: a read and a check per extent visited before the fit, then the
//     relink step (and the split step when split), or a final read if none fits
//   free: a read and a check per extent passed in the list walk, then two
//     link steps and the two merge checks
// Each list step is one read of the next-link ram and a check that uses the
// registered read data; the free list length sets how many steps are taken.
//
// Reset (synchronous, active low): the head points at block 0 and one cycle
// after reset writes the whole-heap extent at block 0, with busy high.
`default_nettype none

module first_fit_block_allocator_unit #(
    parameter int HEAP_BLOCKS = ffba_pkg::HEAP_BLOCKS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_func,
    input  wire logic [ffba_pkg::SIZE_W-1:0]      i_size_blocks,
    input  wire logic [ffba_pkg::INDEX_W-1:0]     i_block_index,
    output logic                                  o_done,
    output logic      [ffba_pkg::STATUS_W-1:0]    o_status,
    output logic      [ffba_pkg::GRANT_W-1:0]     o_granted_block
);

    import ffba_pkg::*;

    localparam int W  = $clog2(HEAP_BLOCKS + 1);
    localparam int AW = $clog2(HEAP_BLOCKS);
    localparam int XW = ((W > SIZE_W) ? W : SIZE_W) + 1;
    localparam logic [W-1:0]  NIL    = W'(HEAP_BLOCKS);
    localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BLOCKS);
    localparam logic [W:0]    HEAP_S = (W+1)'(HEAP_BLOCKS);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_CHK,
        S_A_FIX,
        S_A_SPLIT,
        S_F_RD,
        S_F_CHK,
        S_F_LINK1,
        S_F_LINK2,
        S_J_RD,
        S_J_CHK,
        S_J_RD2,
        S_J_MERGE
    } t_state;

    function automatic logic is_node(input logic [W-1:0] p);
        return p < NIL;
    endfunction

    t_state  r_state, n_state;
    logic    r_done, n_done;
    t_status r_status, n_status;
    logic [GRANT_W-1:0] r_granted, n_granted;
    logic [W-1:0] r_head, n_head;

    logic [W-1:0]      r_cur, n_cur;
    logic [W-1:0]      r_steps, n_steps;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [W-1:0]      r_idx, n_idx;
    logic [W-1:0]      r_nxt, n_nxt;
    logic [W-1:0]      r_prv, n_prv;
    logic [W-1:0]      r_len, n_len;
    logic [W-1:0]      r_tail, n_tail;
    logic              r_exact, n_exact;
    logic [W-1:0]      r_jc, n_jc;
    logic              r_second, n_second;

    logic          nx_we, pv_we, ln_we;
    logic [AW-1:0] nx_waddr, pv_waddr, ln_waddr;
    logic [W-1:0]  nx_wdata, pv_wdata, ln_wdata;
    logic [AW-1:0] nx_raddr, pv_raddr, ln_raddr;
    logic [W-1:0]  nx_rdata, pv_rdata, ln_rdata;

    logic [XW-1:0] tail_x;
    logic [W:0]    sum_s;
    logic          join_end;

    ffba_ram #(.WIDTH(W), .DEPTH(HEAP_BLOCKS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nx_we),
        .i_waddr (nx_waddr),
        .i_wdata (nx_wdata),
        .i_raddr (nx_raddr),
        .o_rdata (nx_rdata)
    );

    ffba_ram #(.WIDTH(W), .DEPTH(HEAP_BLOCKS)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (pv_we),
        .i_waddr (pv_waddr),
        .i_wdata (pv_wdata),
        .i_raddr (pv_raddr),
        .o_rdata (pv_rdata)
    );

    ffba_ram #(.WIDTH(W), .DEPTH(HEAP_BLOCKS)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (ln_wdata),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_done    = 1'b0;
        n_status  = r_status;
        n_granted = r_granted;
        n_head    = r_head;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_size    = r_size;
        n_idx     = r_idx;
        n_nxt     = r_nxt;
        n_prv     = r_prv;
        n_len     = r_len;
        n_tail    = r_tail;
        n_exact   = r_exact;
        n_jc      = r_jc;
        n_second  = r_second;

        nx_we = 1'b0; nx_waddr = '0; nx_wdata = '0; nx_raddr = '0;
        pv_we = 1'b0; pv_waddr = '0; pv_wdata = '0; pv_raddr = '0;
        ln_we = 1'b0; ln_waddr = '0; ln_wdata = '0; ln_raddr = '0;

        tail_x   = XW'(r_cur) + XW'(r_size);
        sum_s    = (W+1)'(r_jc) + (W+1)'(ln_rdata);
        join_end = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // whole heap as one extent at block 0
                nx_we = 1'b1; nx_waddr = '0; nx_wdata = NIL;
                pv_we = 1'b1; pv_waddr = '0; pv_wdata = NIL;
                ln_we = 1'b1; ln_waddr = '0; ln_wdata = NIL;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_size = i_size_blocks;
                    n_idx  = W'(i_block_index);
                    if (t_func'(i_func) == FUNC_ALLOC) begin
                        if (i_size_blocks == '0) begin
                            n_done    = 1'b1;
                            n_status  = ST_NO_FIT;
                            n_granted = '0;
                        end else begin
                            n_cur   = r_head;
                            n_steps = '0;
                            n_state = S_A_RD;
                        end
                    end else if (XW'(i_block_index) >= HEAP_X) begin
                        n_done    = 1'b1;
                        n_status  = ST_RANGE;
                        n_granted = '0;
                    end else if (is_node(r_head) &&
                                 XW'(i_block_index) >= XW'(r_head)) begin
                        n_cur   = r_head;
                        n_steps = '0;
                        n_state = S_F_RD;
                    end else begin
                        n_cur   = NIL;
                        n_nxt   = r_head;
                        n_state = S_F_LINK1;
                    end
                end
            end
            S_A_RD: begin
                nx_raddr = r_cur[AW-1:0];
                pv_raddr = r_cur[AW-1:0];
                ln_raddr = r_cur[AW-1:0];
                if (!is_node(r_cur) || r_steps >= NIL) begin
                    n_done    = 1'b1;
                    n_status  = ST_NO_FIT;
                    n_granted = '0;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (XW'(ln_rdata) >= XW'(r_size)) begin
                    n_exact = (XW'(ln_rdata) == XW'(r_size)) || (tail_x >= HEAP_X);
                    n_prv   = pv_rdata;
                    n_nxt   = nx_rdata;
                    n_len   = ln_rdata;
                    n_tail  = W'(tail_x);
                    n_state = S_A_FIX;
                end else begin
                    n_cur   = nx_rdata;
                    n_steps = r_steps + 1'b1;
                    n_state = S_A_RD;
                end
            end
            S_A_FIX: begin
                // relink neighbors to the tail, or past the extent if taken whole
                if (is_node(r_prv)) begin
                    nx_we    = 1'b1;
                    nx_waddr = r_prv[AW-1:0];
                    nx_wdata = r_exact ? r_nxt : r_tail;
                end else begin
                    n_head = r_exact ? r_nxt : r_tail;
                end
                if (is_node(r_nxt)) begin
                    pv_we    = 1'b1;
                    pv_waddr = r_nxt[AW-1:0];
                    pv_wdata = r_exact ? r_prv : r_tail;
                end
                if (r_exact) begin
                    n_done    = 1'b1;
                    n_status  = ST_DONE;
                    n_granted = GRANT_W'(r_cur);
                    n_state   = S_IDLE;
                end else begin
                    ln_we    = 1'b1;
                    ln_waddr = r_tail[AW-1:0];
                    ln_wdata = r_len - W'(r_size);
                    n_state  = S_A_SPLIT;
                end
            end
            S_A_SPLIT: begin
                nx_we = 1'b1; nx_waddr = r_tail[AW-1:0]; nx_wdata = r_nxt;
                pv_we = 1'b1; pv_waddr = r_tail[AW-1:0]; pv_wdata = r_prv;
                ln_we = 1'b1; ln_waddr = r_cur[AW-1:0];  ln_wdata = W'(r_size);
                n_done    = 1'b1;
                n_status  = ST_DONE;
                n_granted = GRANT_W'(r_cur);
                n_state   = S_IDLE;
            end
            S_F_RD: begin
                nx_raddr = r_cur[AW-1:0];
                n_state  = S_F_CHK;
            end
            S_F_CHK: begin
                if (r_steps < NIL && is_node(nx_rdata) && r_idx > nx_rdata) begin
                    n_cur   = nx_rdata;
                    n_steps = r_steps + 1'b1;
                    n_state = S_F_RD;
                end else begin
                    n_nxt   = nx_rdata;
                    n_state = S_F_LINK1;
                end
            end
            S_F_LINK1: begin
                pv_we = 1'b1; pv_waddr = r_idx[AW-1:0]; pv_wdata = r_cur;
                nx_we = 1'b1; nx_waddr = r_idx[AW-1:0]; nx_wdata = r_nxt;
                n_state = S_F_LINK2;
            end
            S_F_LINK2: begin
                if (is_node(r_nxt)) begin
                    pv_we = 1'b1; pv_waddr = r_nxt[AW-1:0]; pv_wdata = r_idx;
                end
                if (is_node(r_cur)) begin
                    nx_we = 1'b1; nx_waddr = r_cur[AW-1:0]; nx_wdata = r_idx;
                end else begin
                    n_head = r_idx;
                end
                n_jc     = r_idx;
                n_second = 1'b0;
                n_state  = S_J_RD;
            end
            S_J_RD: begin
                nx_raddr = r_jc[AW-1:0];
                ln_raddr = r_jc[AW-1:0];
                n_state  = S_J_CHK;
            end
            S_J_CHK: begin
                // merge only when this extent ends where the next one starts
                if (is_node(nx_rdata) && sum_s == (W+1)'(nx_rdata)) begin
                    n_nxt   = nx_rdata;
                    n_len   = ln_rdata;
                    n_state = S_J_RD2;
                end else begin
                    join_end = 1'b1;
                end
            end
            S_J_RD2: begin
                nx_raddr = r_nxt[AW-1:0];
                ln_raddr = r_nxt[AW-1:0];
                n_state  = S_J_MERGE;
            end
            S_J_MERGE: begin
                sum_s    = (W+1)'(r_len) + (W+1)'(ln_rdata);
                ln_we    = 1'b1;
                ln_waddr = r_jc[AW-1:0];
                ln_wdata = (sum_s > HEAP_S) ? NIL : W'(sum_s);
                nx_we    = 1'b1;
                nx_waddr = r_jc[AW-1:0];
                nx_wdata = nx_rdata;
                if (is_node(nx_rdata)) begin
                    pv_we = 1'b1; pv_waddr = nx_rdata[AW-1:0]; pv_wdata = r_jc;
                end
                join_end = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // after the merge check at the freed block, repeat it at its predecessor
        if (join_end) begin
            if (!r_second && is_node(r_cur)) begin
                n_second = 1'b1;
                n_jc     = r_cur;
                n_state  = S_J_RD;
            end else begin
                n_done    = 1'b1;
                n_status  = ST_DONE;
                n_granted = '0;
                n_state   = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_done    <= 1'b0;
            r_status  <= ST_DONE;
            r_granted <= '0;
            r_head    <= '0;
        end else begin
            r_state   <= n_state;
            r_done    <= n_done;
            r_status  <= n_status;
            r_granted <= n_granted;
            r_head    <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_size   <= n_size;
        r_idx    <= n_idx;
        r_nxt    <= n_nxt;
        r_prv    <= n_prv;
        r_len    <= n_len;
        r_tail   <= n_tail;
        r_exact  <= n_exact;
        r_jc     <= n_jc;
        r_second <= n_second;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_granted_block = r_granted;

endmodule

`default_nettype wire

FILE: sv/ffba_checker.sv
// port-level checks for the first-fit block allocator, bound to the top level
`default_nettype none

module ffba_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             i_func,
    input wire logic                             o_done,
    input wire logic [ffba_pkg::STATUS_W-1:0]    o_status,
    input wire logic [ffba_pkg::GRANT_W-1:0]     o_granted_block
);

    import ffba_pkg::*;

    // result beat only in a cycle where a new request may be taken
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // an accepted request either answers at once or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted request dropped");

    // every result beat follows an accept or a busy cycle
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy || start))
        else $error("result beat without a request");

    // failed requests report no granted block
    a_fail_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_DONE) |-> (o_granted_block == '0))
        else $error("nonzero grant on failure");

    // range errors come only from a free answered right after its accept
    a_range_from_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_RANGE) |->
            $past(start && !busy && (i_func == FUNC_FREE)))
        else $error("range status not from an immediate free");

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_func          (i_func),
    .o_done          (o_done),
    .o_status        (o_status),
    .o_granted_block (o_granted_block)
);

`default_nettype wire
